@@ sv/des_key_schedule_macros.svh @@
// Assertion helpers for the DES key schedule.
`ifndef DES_KEY_SCHEDULE_MACROS_SVH
`define DES_KEY_SCHEDULE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define DKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/dks_pkg.sv @@
package dks_pkg;

  localparam int ROUNDS      = 16;
  localparam int HALF_BITS   = 28;
  localparam int CD_BITS     = 2 * HALF_BITS;
  localparam int SUBKEY_BITS = 48;
  localparam int KEY_BITS    = 64;
  localparam int IDX_BITS    = $clog2(ROUNDS);
  localparam int ROT_BITS    = $clog2(HALF_BITS);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ROUNDS - 1);

  // One subkey slot of the chain.
  typedef struct packed {
    logic                   valid;
    logic [SUBKEY_BITS-1:0] key;
    logic [IDX_BITS-1:0]    idx;
  } ks_beat_t;

  typedef struct packed {
    logic load;
    logic shift;
  } ks_ctl_t;

  // Key position (0 = key bit 63) feeding each C|D bit.
  localparam logic [5:0] PC1_TAB [CD_BITS] = '{
    6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,  6'd0,  6'd57, 6'd49, 6'd41, 6'd33,
    6'd25, 6'd17, 6'd9,  6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,
    6'd59, 6'd51, 6'd43, 6'd35, 6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22, 6'd14, 6'd6,
    6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21, 6'd13, 6'd5,  6'd60, 6'd52, 6'd44, 6'd36,
    6'd28, 6'd20, 6'd12, 6'd4,  6'd27, 6'd19, 6'd11, 6'd3
  };

  // C|D position (0 = first bit of C) feeding each subkey bit.
  localparam logic [5:0] PC2_TAB [SUBKEY_BITS] = '{
    6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27, 6'd14, 6'd5,  6'd20, 6'd9,
    6'd22, 6'd18, 6'd11, 6'd3,  6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
    6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39, 6'd50, 6'd44, 6'd32, 6'd47,
    6'd43, 6'd48, 6'd38, 6'd55, 6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31
  };

  // Total left rotation of the halves at each round, mod 28.
  localparam logic [ROT_BITS-1:0] ENC_ROT_CUM [ROUNDS] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
  };

  // Decrypt rotates right; stored as the equivalent left amount.
  localparam logic [ROT_BITS-1:0] DEC_ROT_CUM [ROUNDS] = '{
    5'd0,  5'd27, 5'd25, 5'd23, 5'd21, 5'd19, 5'd17, 5'd15,
    5'd14, 5'd12, 5'd10, 5'd8,  5'd6,  5'd4,  5'd2,  5'd1
  };

  function automatic logic [CD_BITS-1:0] pc1(input logic [KEY_BITS-1:0] k);
    logic [CD_BITS-1:0] cd;
    for (int i = 0; i < CD_BITS; i++) begin
      cd[CD_BITS-1-i] = k[KEY_BITS-1-int'(PC1_TAB[i])];
    end
    return cd;
  endfunction

  function automatic logic [SUBKEY_BITS-1:0] pc2(input logic [CD_BITS-1:0] cd);
    logic [SUBKEY_BITS-1:0] r;
    for (int i = 0; i < SUBKEY_BITS; i++) begin
      r[SUBKEY_BITS-1-i] = cd[CD_BITS-1-int'(PC2_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [ROT_BITS-1:0] rot_amt(input logic [IDX_BITS-1:0] idx,
                                                  input logic cmd);
    return cmd ? DEC_ROT_CUM[idx] : ENC_ROT_CUM[idx];
  endfunction

  function automatic logic [HALF_BITS-1:0] rotl28(input logic [HALF_BITS-1:0] x,
                                                 input logic [ROT_BITS-1:0] n);
    logic [2*HALF_BITS-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*HALF_BITS-1:HALF_BITS];
  endfunction

endpackage

@@ sv/dks_cell.sv @@
module dks_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dks_pkg::ks_ctl_t                ctl_i,
  input  logic [dks_pkg::CD_BITS-1:0]     cd_i,
  input  logic                            cmd_i,
  input  logic [dks_pkg::IDX_BITS-1:0]    idx_i,
  input  dks_pkg::ks_beat_t               nb_i,
  output dks_pkg::ks_beat_t               beat_o
);
  import dks_pkg::*;

  logic [ROT_BITS-1:0]  rot;
  logic [HALF_BITS-1:0] c_rot;
  logic [HALF_BITS-1:0] d_rot;
  ks_beat_t             beat_r;
  ks_beat_t             beat_nxt;

  // halves rotated to this slot's round
  always_comb begin
    rot   = rot_amt(idx_i, cmd_i);
    c_rot = rotl28(cd_i[CD_BITS-1:HALF_BITS], rot);
    d_rot = rotl28(cd_i[HALF_BITS-1:0], rot);
  end

  always_comb begin
    beat_nxt = beat_r;
    if (ctl_i.load) begin
      beat_nxt.valid = 1'b1;
      beat_nxt.key   = pc2({c_rot, d_rot});
      beat_nxt.idx   = idx_i;
    end else if (ctl_i.shift) begin
      beat_nxt = nb_i;
    end
  end

  // only the valid bit is reset; key and index follow it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.key <= beat_nxt.key;
    beat_r.idx <= beat_nxt.idx;
  end

  assign beat_o = beat_r;

endmodule

@@ sv/des_key_schedule.sv @@
// DES key schedule.
// Input channel (in_*): one beat carries a 64-bit key in in_tdata and the
// direction in in_tuser (0 = encrypt order K1..K16, 1 = decrypt K16..K1).
// Output channel (out_*): sixteen beats per key, one subkey each. out_tdata
// holds the 48-bit subkey and its 4-bit position in the run; out_tlast
// marks the sixteenth beat.
// A key beat lands in a one-deep holding register after PC-1. When the
// subkey chain is free, all sixteen cells load their subkeys together;
// the chain then shifts one cell toward the output on each taken beat.
// With the chain empty, an accepted key passes the holding register and
// then the cell registers before its first subkey is valid at the output.
// The key rate is bounded by the single output port, which drains
// the sixteen-cell chain. The next key reloads the chain in the same cycle
// the previous run's last beat is taken, so runs follow with no gap, and
// the holding register takes the key after that during the current run.
// A stalled receiver freezes the chain; the held key waits, in_tready drops.
// Reset (rst_n low, synchronous) empties the chain and the holding register.
`include "des_key_schedule_macros.svh"

module des_key_schedule (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] key_bits
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [47:0] round_key, [51:48] round_index, [55:52] zero
  output logic        out_tlast
);
  import dks_pkg::*;

  // Holding register, key already through PC-1.
  logic               pend_v_r;
  logic               pend_v_nxt;
  logic [CD_BITS-1:0] pend_cd_r;
  logic               pend_cmd_r;

  ks_ctl_t  ctl;
  ks_beat_t beat [ROUNDS];
  ks_beat_t nb   [ROUNDS];

  logic in_acc;
  logic out_acc;

  assign in_tready = !pend_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // Load only when nothing but the outgoing last beat is left in the chain.
  assign ctl.load  = pend_v_r && !beat[1].valid && (!beat[0].valid || out_tready);
  assign ctl.shift = out_acc;

  assign pend_v_nxt = (pend_v_r && !ctl.load) || in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_cd_r  <= pc1(in_tdata);
      pend_cmd_r <= in_tuser;
    end
  end

  // Row of subkey cells; cell 0 faces the output.
  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    if (g == ROUNDS - 1) begin : g_tail
      assign nb[g] = '0;
    end else begin : g_mid
      assign nb[g] = beat[g+1];
    end

    dks_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .cd_i   (pend_cd_r),
      .cmd_i  (pend_cmd_r),
      .idx_i  (IDX_BITS'(g)),
      .nb_i   (nb[g]),
      .beat_o (beat[g])
    );
  end

  assign out_tvalid = beat[0].valid;
  assign out_tdata  = {{(56 - SUBKEY_BITS - IDX_BITS){1'b0}}, beat[0].idx, beat[0].key};
  assign out_tlast  = (beat[0].idx == LAST_IDX);

  // Run stays in order: a taken non-last beat is followed by its successor.
  `DKS_ASSERT_NEXT(a_idx_step, clk, rst_n, out_acc && !out_tlast,
    out_tvalid && (beat[0].idx == $past(beat[0].idx) + 4'd1), "subkey run broken")
  // A reload never lands on a run still in the chain.
  `DKS_ASSERT_NOW(a_load_empty, clk, rst_n, ctl.load,
    !beat[1].valid && !beat[ROUNDS-1].valid, "chain reloaded while busy")
  // A filled tail cell implies filled cells at the output end.
  `DKS_ASSERT_NOW(a_contig, clk, rst_n, beat[ROUNDS-1].valid,
    beat[0].valid && beat[1].valid, "gap in subkey chain")
  // Only the last beat may sit alone at the output.
  `DKS_ASSERT_NOW(a_last_alone, clk, rst_n, out_tvalid && !beat[1].valid,
    out_tlast, "run ended early")

endmodule
